[rtl/pbe_pkg.sv]
// ----------------------------------------------------------------------------
// pbe_pkg: shared types and constants for the packed 2bpp pixel engine
// Command codes, payload structs, controller states and the controller /
// datapath interface.
// ----------------------------------------------------------------------------
package pbe_pkg;

	typedef enum logic [2:0] {
		CMD_WRITE = 3'd0,
		CMD_READ  = 3'd1,
		CMD_HSPAN = 3'd2,
		CMD_VSPAN = 3'd3,
		CMD_COPY  = 3'd4
	} cmd_code_t;

	localparam logic [1:0] REG_LINE_BYTES = 2'd0;
	localparam logic [1:0] REG_WIDTH      = 2'd1;
	localparam logic [1:0] REG_HEIGHT     = 2'd2;
	localparam logic [1:0] REG_RASTER_OP  = 2'd3;

	localparam logic [8:0]  LINE_BYTES_RST = 9'd40;
	localparam logic [10:0] WIDTH_RST      = 11'd160;
	localparam logic [10:0] HEIGHT_RST     = 11'd128;

	localparam logic [7:0] KEEP_MASK [4] = '{8'hfc, 8'hf3, 8'hcf, 8'h3f};
	localparam logic [1:0] PIX_MASK = 2'h3;

	typedef struct packed {
		logic [2:0]  command;
		logic [9:0]  x;
		logic [9:0]  y;
		logic [9:0]  x_end;
		logic [9:0]  y_end;
		logic [10:0] width;
		logic [10:0] height;
		logic [9:0]  src_x;
		logic [9:0]  src_y;
		logic [1:0]  color;
	} item_t;

	typedef struct packed {
		logic [1:0]  read_value;
		logic        status;
		logic [10:0] upd_x0;
		logic [10:0] upd_y0;
		logic [11:0] upd_x1;
		logic [11:0] upd_y1;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHKA,
		ST_CHKB,
		ST_DECIDE,
		ST_SADDR,
		ST_SRD,
		ST_SGET,
		ST_DADDR,
		ST_DRD,
		ST_RGET,
		ST_DWR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MS_PA,
		MS_PB,
		MS_SRC,
		MS_DST
	} mul_sel_t;

	typedef struct packed {
		logic     clr_en;
		logic     load;
		logic     addr_en;
		mul_sel_t mul_sel;
		logic     chk_a;
		logic     decide;
		logic     rd_en;
		logic     get_rv;
		logic     get_pix;
		logic     wr_en;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] command;
		logic       ok;
		logic       last;
		logic       clr_last;
	} dp_stat_t;

endpackage

[rtl/pbe_ctrl.sv]
// ----------------------------------------------------------------------------
// pbe_ctrl: command sequencer
// Steps the datapath through the clearing pass, the checks and the
// per-pixel read-modify-write loop.
// ----------------------------------------------------------------------------
module pbe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output pbe_pkg::dp_cmd_t  dcmd,
	input  pbe_pkg::dp_stat_t dstat
);

	pbe_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbe_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dcmd    = '0;
		dcmd.mul_sel = pbe_pkg::MS_DST;
		busy    = (state_q != pbe_pkg::ST_IDLE);
		done    = 1'b0;
		unique case (state_q)
			pbe_pkg::ST_CLEAR: begin
				dcmd.clr_en = 1'b1;
				if (dstat.clr_last) state_d = pbe_pkg::ST_IDLE;
			end
			pbe_pkg::ST_IDLE: begin
				if (start) begin
					dcmd.load = 1'b1;
					state_d   = pbe_pkg::ST_CHKA;
				end
			end
			pbe_pkg::ST_CHKA: begin
				dcmd.mul_sel = pbe_pkg::MS_PA;
				dcmd.addr_en = 1'b1;
				state_d      = pbe_pkg::ST_CHKB;
			end
			pbe_pkg::ST_CHKB: begin
				dcmd.chk_a   = 1'b1;
				dcmd.mul_sel = pbe_pkg::MS_PB;
				dcmd.addr_en = 1'b1;
				state_d      = pbe_pkg::ST_DECIDE;
			end
			pbe_pkg::ST_DECIDE: begin
				dcmd.decide = 1'b1;
				if (!dstat.ok) state_d = pbe_pkg::ST_DONE;
				else if (dstat.command == pbe_pkg::CMD_COPY) state_d = pbe_pkg::ST_SADDR;
				else state_d = pbe_pkg::ST_DADDR;
			end
			pbe_pkg::ST_SADDR: begin
				dcmd.mul_sel = pbe_pkg::MS_SRC;
				dcmd.addr_en = 1'b1;
				state_d      = pbe_pkg::ST_SRD;
			end
			pbe_pkg::ST_SRD: begin
				dcmd.rd_en = 1'b1;
				state_d    = pbe_pkg::ST_SGET;
			end
			pbe_pkg::ST_SGET: begin
				dcmd.get_pix = 1'b1;
				state_d      = pbe_pkg::ST_DADDR;
			end
			pbe_pkg::ST_DADDR: begin
				dcmd.mul_sel = pbe_pkg::MS_DST;
				dcmd.addr_en = 1'b1;
				state_d      = pbe_pkg::ST_DRD;
			end
			pbe_pkg::ST_DRD: begin
				dcmd.rd_en = 1'b1;
				if (dstat.command == pbe_pkg::CMD_READ) state_d = pbe_pkg::ST_RGET;
				else state_d = pbe_pkg::ST_DWR;
			end
			pbe_pkg::ST_RGET: begin
				dcmd.get_rv = 1'b1;
				state_d     = pbe_pkg::ST_DONE;
			end
			pbe_pkg::ST_DWR: begin
				dcmd.wr_en = 1'b1;
				if (dstat.last) state_d = pbe_pkg::ST_DONE;
				else if (dstat.command == pbe_pkg::CMD_COPY) state_d = pbe_pkg::ST_SADDR;
				else state_d = pbe_pkg::ST_DADDR;
			end
			pbe_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = pbe_pkg::ST_IDLE;
			end
			default: state_d = pbe_pkg::ST_IDLE;
		endcase
	end

endmodule

[rtl/pbe_dp.sv]
// ----------------------------------------------------------------------------
// pbe_dp: pixel engine datapath
// Holds the command, the byte store, the address multiplier, the range
// checks and the pixel loop counters.
// ----------------------------------------------------------------------------
module pbe_dp #(
	parameter int STORE_BYTES = 8192,
	parameter int COORD_LIMIT = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pbe_pkg::item_t    item,
	input  logic [8:0]        line_bytes,
	input  logic [10:0]       width_pixels,
	input  logic [10:0]       height_pixels,
	input  logic              raster_op,
	input  pbe_pkg::dp_cmd_t  dcmd,
	output pbe_pkg::dp_stat_t dstat,
	output pbe_pkg::result_t  result
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int CW = 13;
	localparam logic [CW-1:0] LIMIT = CW'(COORD_LIMIT);
	localparam logic [21:0] STORE_END = 22'(STORE_BYTES);
	localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);

	logic [7:0] mem [STORE_BYTES];

	pbe_pkg::item_t it_q;
	logic [AW-1:0]  clr_q;
	logic [21:0]    addr_q;
	logic [10:0]    i_q, j_q;
	logic           oka_q, ok_q;
	logic [7:0]     rd_q;
	logic [1:0]     pix_q, rv_q;

	logic [CW-1:0] wb, hb;
	logic [11:0]   px, py;
	logic [10:0]   lim_i, lim_j;
	logic [11:0]   dx, sxc;
	logic          range_ok;
	logic [1:0]    wsh, cval;
	logic [7:0]    cbyte, nbyte;

	assign wb = ({2'b0, width_pixels} > LIMIT) ? LIMIT : {2'b0, width_pixels};
	assign hb = ({2'b0, height_pixels} > LIMIT) ? LIMIT : {2'b0, height_pixels};

	assign dx  = 12'(it_q.x) + 12'(i_q);
	assign sxc = 12'(it_q.src_x) + 12'(i_q);

	always_comb begin
		logic in_xy;
		in_xy = (CW'(it_q.x) < wb) && (CW'(it_q.y) < hb);
		unique case (it_q.command)
			pbe_pkg::CMD_WRITE, pbe_pkg::CMD_READ: range_ok = in_xy;
			pbe_pkg::CMD_HSPAN:
				range_ok = in_xy && (CW'(it_q.x_end) < wb) && (it_q.x_end >= it_q.x);
			pbe_pkg::CMD_VSPAN:
				range_ok = in_xy && (CW'(it_q.y_end) < hb) && (it_q.y_end >= it_q.y);
			pbe_pkg::CMD_COPY:
				range_ok = in_xy && (it_q.width != '0) && (it_q.height != '0) &&
					(CW'(it_q.src_x) < wb) && (CW'(it_q.src_y) < hb) &&
					(CW'(it_q.x) + CW'(it_q.width) <= wb) &&
					(CW'(it_q.y) + CW'(it_q.height) <= hb) &&
					(CW'(it_q.src_x) + CW'(it_q.width) <= wb) &&
					(CW'(it_q.src_y) + CW'(it_q.height) <= hb);
			default: range_ok = 1'b0;
		endcase
	end

	// loop limits: span length or rectangle size minus one
	always_comb begin
		lim_i = '0;
		lim_j = '0;
		unique case (it_q.command)
			pbe_pkg::CMD_HSPAN: lim_i = 11'(it_q.x_end - it_q.x);
			pbe_pkg::CMD_VSPAN: lim_j = 11'(it_q.y_end - it_q.y);
			pbe_pkg::CMD_COPY: begin
				lim_i = it_q.width - 11'd1;
				lim_j = it_q.height - 11'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (dcmd.mul_sel)
			pbe_pkg::MS_PA: begin
				unique case (it_q.command)
					pbe_pkg::CMD_HSPAN: begin
						px = 12'(it_q.x_end);
						py = 12'(it_q.y);
					end
					pbe_pkg::CMD_VSPAN: begin
						px = 12'(it_q.x);
						py = 12'(it_q.y_end);
					end
					pbe_pkg::CMD_COPY: begin
						px = 12'(it_q.x) + 12'(it_q.width) - 12'd1;
						py = 12'(it_q.y) + 12'(it_q.height) - 12'd1;
					end
					default: begin
						px = 12'(it_q.x);
						py = 12'(it_q.y);
					end
				endcase
			end
			pbe_pkg::MS_PB: begin
				px = 12'(it_q.src_x) + 12'(it_q.width) - 12'd1;
				py = 12'(it_q.src_y) + 12'(it_q.height) - 12'd1;
			end
			pbe_pkg::MS_SRC: begin
				px = sxc;
				py = 12'(it_q.src_y) + 12'(j_q);
			end
			pbe_pkg::MS_DST: begin
				px = dx;
				py = 12'(it_q.y) + 12'(j_q);
			end
			default: begin
				px = '0;
				py = '0;
			end
		endcase
	end

	// pixel modify: copy always replaces, otherwise raster_op picks XOR
	assign wsh   = dx[1:0];
	assign cval  = (it_q.command == pbe_pkg::CMD_COPY) ? pix_q : it_q.color;
	assign cbyte = 8'(cval) << {wsh, 1'b0};
	assign nbyte = (raster_op && (it_q.command != pbe_pkg::CMD_COPY)) ?
		(rd_q ^ cbyte) : ((rd_q & pbe_pkg::KEEP_MASK[wsh]) | cbyte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			ok_q  <= 1'b0;
		end else begin
			if (dcmd.clr_en) clr_q <= clr_q + AW'(1);
			if (dcmd.load) ok_q <= 1'b0;
			if (dcmd.decide) ok_q <= dstat.ok;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			it_q <= item;
			i_q  <= '0;
			j_q  <= '0;
			rv_q <= '0;
		end
		if (dcmd.addr_en) addr_q <= 22'(px[11:2]) + 22'(py) * 22'(line_bytes);
		if (dcmd.chk_a) oka_q <= (addr_q < STORE_END);
		if (dcmd.rd_en) rd_q <= mem[addr_q[AW-1:0]];
		if (dcmd.get_pix)
			pix_q <= 2'((rd_q >> {sxc[1:0], 1'b0}) & 8'(pbe_pkg::PIX_MASK));
		if (dcmd.get_rv) rv_q <= 2'(rd_q >> {dx[1:0], 1'b0});
		if (dcmd.wr_en) begin
			// advance left to right, then down a row
			if (i_q == lim_i) begin
				i_q <= '0;
				j_q <= j_q + 11'd1;
			end else begin
				i_q <= i_q + 11'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.clr_en) mem[clr_q] <= '0;
		else if (dcmd.wr_en) mem[addr_q[AW-1:0]] <= nbyte;
	end

	always_comb begin
		dstat.command  = it_q.command;
		dstat.ok       = range_ok && oka_q &&
			((it_q.command != pbe_pkg::CMD_COPY) || (addr_q < STORE_END));
		dstat.last     = (i_q == lim_i) && (j_q == lim_j);
		dstat.clr_last = (clr_q == CLR_LAST);
	end

	always_comb begin
		result = '0;
		result.status = !ok_q;
		if (ok_q) begin
			result.read_value = rv_q;
			if (it_q.command != pbe_pkg::CMD_READ) begin
				result.upd_x0 = 11'(it_q.x);
				result.upd_y0 = 11'(it_q.y);
				result.upd_x1 = 12'(it_q.x);
				result.upd_y1 = 12'(it_q.y);
			end
			unique case (it_q.command)
				pbe_pkg::CMD_HSPAN: result.upd_x1 = 12'(it_q.x_end);
				pbe_pkg::CMD_VSPAN: result.upd_y1 = 12'(it_q.y_end);
				pbe_pkg::CMD_COPY: begin
					result.upd_x1 = 12'(it_q.x) + 12'(it_q.width);
					result.upd_y1 = 12'(it_q.y) + 12'(it_q.height);
				end
				default: ;
			endcase
		end
	end

endmodule

[rtl/packed_2bpp_pixel_engine.sv]
// ----------------------------------------------------------------------------
// packed_2bpp_pixel_engine: 2bpp frame store with pixel, span and copy ops
// Command in on start/busy, one result per command on a done strobe,
// registers on an APB-style port.
// ----------------------------------------------------------------------------
// Steps: checks, then per pixel an address, a read and a write for writes and
//   spans; copies first do a source address, read and fetch (one store port).
//   Read pixel: address, read, fetch. Rejected: checks only. Each ends in done.
// Throughput: one command at a time; busy stays high until done.
// Reset: clears the store in a pass over all STORE_BYTES bytes with busy high;
//   registers take their reset values at once. The receiver cannot stall.
module packed_2bpp_pixel_engine #(
	parameter int STORE_BYTES = 8192,
	parameter int COORD_LIMIT = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             start,
	output logic             busy,
	input  pbe_pkg::item_t   item,
	output logic             done,
	output pbe_pkg::result_t result
);

	logic [8:0]  line_bytes_q;
	logic [10:0] width_q, height_q;
	logic        raster_op_q;
	logic        wr_xact;

	pbe_pkg::dp_cmd_t  dcmd;
	pbe_pkg::dp_stat_t dstat;

	assign pready  = 1'b1;
	// a write transaction completes on the access cycle
	assign wr_xact = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q <= pbe_pkg::LINE_BYTES_RST;
			width_q      <= pbe_pkg::WIDTH_RST;
			height_q     <= pbe_pkg::HEIGHT_RST;
			raster_op_q  <= 1'b0;
		end else if (wr_xact) begin
			unique case (paddr[3:2])
				pbe_pkg::REG_LINE_BYTES: line_bytes_q <= pwdata[8:0];
				pbe_pkg::REG_WIDTH:      width_q      <= pwdata[10:0];
				pbe_pkg::REG_HEIGHT:     height_q     <= pwdata[10:0];
				pbe_pkg::REG_RASTER_OP:  raster_op_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back the addressed register, zero-extended
	always_comb begin
		unique case (paddr[3:2])
			pbe_pkg::REG_LINE_BYTES: prdata = 32'(line_bytes_q);
			pbe_pkg::REG_WIDTH:      prdata = 32'(width_q);
			pbe_pkg::REG_HEIGHT:     prdata = 32'(height_q);
			pbe_pkg::REG_RASTER_OP:  prdata = 32'(raster_op_q);
			default:                 prdata = '0;
		endcase
	end

	pbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.dcmd   (dcmd),
		.dstat  (dstat)
	);

	pbe_dp #(
		.STORE_BYTES (STORE_BYTES),
		.COORD_LIMIT (COORD_LIMIT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.line_bytes    (line_bytes_q),
		.width_pixels  (width_q),
		.height_pixels (height_q),
		.raster_op     (raster_op_q),
		.dcmd          (dcmd),
		.dstat         (dstat),
		.result        (result)
	);

endmodule
